>>> rtl/core/rgbtp_pkg.sv
package rgbtp_pkg;

	localparam int unsigned ChW    = 8;
	localparam int unsigned ColorW = 24;
	localparam int unsigned AccW   = 10;
	localparam int unsigned CompW  = 8;

	localparam logic [ChW-1:0] CH_ZERO  = 8'h30;
	localparam logic [ChW-1:0] CH_NINE  = 8'h39;
	localparam logic [ChW-1:0] CH_COMMA = 8'h2C;
	localparam logic [ChW-1:0] CH_SPACE = 8'h20;
	localparam logic [ChW-1:0] CH_TAB   = 8'h09;
	localparam logic [ChW-1:0] CH_CR    = 8'h0D;

	localparam logic [AccW-1:0] COMP_MAX = 10'h0FF;

	localparam logic TGT_CEILING = 1'b0;
	localparam logic TGT_FLOOR   = 1'b1;

	typedef struct packed {
		logic [ChW-1:0] ch;
		logic           last;
		logic           target;
		logic           already_entered;
		logic           map_started;
	} in_item_t;

	typedef struct packed {
		logic              status;
		logic              which;
		logic [ColorW-1:0] color;
	} res_t;

endpackage

>>> rtl/core/rgbtp_if.sv
interface rgbtp_in_if;
	import rgbtp_pkg::*;

	logic           valid;
	logic           ready;
	logic [ChW-1:0] ch;
	logic           last;
	logic           target;
	logic           already_entered;
	logic           map_started;

	modport source(output valid, ch, last, target, already_entered, map_started, input ready);
	modport sink(input valid, ch, last, target, already_entered, map_started, output ready);
endinterface

interface rgbtp_out_if;
	import rgbtp_pkg::*;

	logic              valid;
	logic              ready;
	logic              status;
	logic              which;
	logic [ColorW-1:0] color;

	modport source(output valid, status, which, color, input ready);
	modport sink(input valid, status, which, color, output ready);
endinterface

>>> rtl/core/rgb_triplet_text_parser.sv
// A line's result is registered and shown in the cycle after its last character.
// Throughput: one character per cycle unless stalled; state updates per transfer.
// Characters are taken whenever the result register is empty or being drained.
// Reset clears the parse state, both color registers and the result valid.
module rgb_triplet_text_parser
	import rgbtp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	rgbtp_in_if.sink     chars,
	rgbtp_out_if.source  result
);

	in_item_t          item;
	res_t              res;
	logic              accept, can_load;
	logic [ColorW-1:0] floor_rgb, ceil_rgb;

	assign item.ch              = chars.ch;
	assign item.last            = chars.last;
	assign item.target          = chars.target;
	assign item.already_entered = chars.already_entered;
	assign item.map_started     = chars.map_started;

	assign chars.ready = can_load;
	assign accept      = chars.valid && can_load;

	rgbtp_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.res       (res),
		.floor_rgb (floor_rgb),
		.ceil_rgb  (ceil_rgb)
	);

	rgbtp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept && item.last),
		.res_d    (res),
		.can_load (can_load),
		.result   (result)
	);

	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && chars.last |=> result.valid)
		else $error("line end without result");

	a_fail_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.status |-> (result.color == '0) && !result.which)
		else $error("failure carries a color");

	a_floor_stored: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status && result.which |-> floor_rgb == result.color)
		else $error("floor color not stored");

	a_ceiling_stored: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.status && !result.which |-> ceil_rgb == result.color)
		else $error("ceiling color not stored");

endmodule

>>> rtl/core/rgbtp_parse.sv
module rgbtp_parse
	import rgbtp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  in_item_t          item,
	output res_t              res,
	output logic [ColorW-1:0] floor_rgb,
	output logic [ColorW-1:0] ceil_rgb
);

	typedef enum logic [1:0] {
		PH_IDENT,
		PH_SPACE,
		PH_FIELD
	} phase_t;

	phase_t              phase_q, n_phase;
	logic [1:0]          field_q, n_field;
	logic [1:0]          digits_q, n_digits;
	logic                lzero_q, n_lzero;
	logic [AccW-1:0]     acc_q, n_acc;
	logic                bad_q, n_bad;
	logic [2*CompW-1:0]  rg_q, n_rg;
	logic [ColorW-1:0]   floor_q, ceiling_q;

	logic                is_digit, is_comma, is_space, field_go, ok;
	logic [AccW-1:0]     acc_x10;

	assign is_digit = (item.ch >= CH_ZERO) && (item.ch <= CH_NINE);
	assign is_comma = item.ch == CH_COMMA;
	assign is_space = (item.ch == CH_SPACE) || ((item.ch >= CH_TAB) && (item.ch <= CH_CR));
	assign acc_x10  = AccW'({acc_q, 3'b000} + {2'b00, acc_q, 1'b0});

	always_comb begin
		n_phase  = phase_q;
		n_field  = field_q;
		n_digits = digits_q;
		n_lzero  = lzero_q;
		n_acc    = acc_q;
		n_bad    = bad_q;
		n_rg     = rg_q;
		field_go = 1'b0;
		if (!bad_q) begin
			unique case (phase_q)
				PH_IDENT: n_phase = PH_SPACE;
				PH_SPACE: begin
					if (!is_space) begin
						n_phase  = PH_FIELD;
						field_go = 1'b1;
					end
				end
				PH_FIELD: field_go = 1'b1;
				default:  n_phase = PH_IDENT;
			endcase
		end
		if (field_go) begin
			if (is_digit) begin
				if ((digits_q == 2'd3) || ((digits_q == 2'd1) && lzero_q)) begin
					n_bad = 1'b1;
				end else begin
					if (digits_q == 2'd0) begin
						n_lzero = item.ch == CH_ZERO;
					end
					n_acc    = acc_x10 + AccW'(item.ch - CH_ZERO);
					n_digits = digits_q + 2'd1;
				end
			end else if (is_comma) begin
				if ((digits_q == 2'd0) || (field_q == 2'd2) || (acc_q > COMP_MAX)) begin
					n_bad = 1'b1;
				end else begin
					n_rg     = {rg_q[CompW-1:0], acc_q[CompW-1:0]};
					n_field  = field_q + 2'd1;
					n_digits = 2'd0;
					n_lzero  = 1'b0;
					n_acc    = '0;
				end
			end else begin
				n_bad = 1'b1;
			end
		end
		ok = !n_bad && (n_phase == PH_FIELD) && (n_field == 2'd2) && (n_digits != 2'd0)
			&& (n_acc <= COMP_MAX) && !item.already_entered && !item.map_started;
		res.status = ok;
		res.which  = ok & item.target;
		res.color  = ok ? {n_rg, n_acc[CompW-1:0]} : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDENT;
			field_q   <= '0;
			digits_q  <= '0;
			lzero_q   <= 1'b0;
			acc_q     <= '0;
			bad_q     <= 1'b0;
			rg_q      <= '0;
			floor_q   <= '0;
			ceiling_q <= '0;
		end else if (accept) begin
			if (item.last) begin
				phase_q  <= PH_IDENT;
				field_q  <= '0;
				digits_q <= '0;
				lzero_q  <= 1'b0;
				acc_q    <= '0;
				bad_q    <= 1'b0;
				rg_q     <= '0;
				if (ok) begin
					if (item.target == TGT_FLOOR) begin
						floor_q <= res.color;
					end else begin
						ceiling_q <= res.color;
					end
				end
			end else begin
				phase_q  <= n_phase;
				field_q  <= n_field;
				digits_q <= n_digits;
				lzero_q  <= n_lzero;
				acc_q    <= n_acc;
				bad_q    <= n_bad;
				rg_q     <= n_rg;
			end
		end
	end

	assign floor_rgb = floor_q;
	assign ceil_rgb  = ceiling_q;

endmodule

>>> rtl/core/rgbtp_out_reg.sv
module rgbtp_out_reg
	import rgbtp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  res_t         res_d,
	output logic         can_load,
	rgbtp_out_if.source  result
);

	logic valid_q;
	res_t res_q;

	assign can_load = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign result.valid  = valid_q;
	assign result.status = res_q.status;
	assign result.which  = res_q.which;
	assign result.color  = res_q.color;

endmodule

>>> tb/sv/rgb_triplet_text_parser_test.sv
module rgb_triplet_text_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rgbtp_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int CHAR_COUNT = 1300;
	localparam int IDLE_LIMIT = 4000;

	typedef enum logic [1:0] {
		LINE_IDENT,
		LINE_BLANKS,
		LINE_FIELDS
	} line_phase_e;

	class color_line_scoreboard;
		line_phase_e      phase;
		logic [1:0]       field_idx;
		logic [2:0]       digits;
		logic             lead_zero;
		logic [AccW-1:0]  acc;
		logic             bad;
		logic [15:0]      red_green;
		logic [ColorW-1:0] floor_rgb;
		logic [ColorW-1:0] ceil_rgb;
		res_t             pending_colors[$];
		int unsigned      fails;
		int unsigned      entered_count;
		int unsigned      rejected_count;

		function new();
			clear_line();
			floor_rgb      = '0;
			ceil_rgb       = '0;
			fails          = 0;
			entered_count  = 0;
			rejected_count = 0;
		endfunction

		function void clear_line();
			phase     = LINE_IDENT;
			field_idx = '0;
			digits    = '0;
			lead_zero = 1'b0;
			acc       = '0;
			bad       = 1'b0;
			red_green = '0;
		endfunction

		function bit is_blank(logic [ChW-1:0] c);
			return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
		endfunction

		function void take_field_char(logic [ChW-1:0] c);
			if (c >= CH_ZERO && c <= CH_NINE) begin
				if (digits >= 3 || (digits == 1 && lead_zero)) begin
					bad = 1'b1;
					return;
				end
				if (digits == 0)
					lead_zero = (c == CH_ZERO);
				acc = AccW'(acc * 10 + (c - CH_ZERO));
				digits++;
			end else if (c == CH_COMMA) begin
				if (digits == 0 || field_idx >= 2 || acc > COMP_MAX) begin
					bad = 1'b1;
					return;
				end
				red_green = {red_green[7:0], acc[CompW-1:0]};
				field_idx++;
				digits    = '0;
				lead_zero = 1'b0;
				acc       = '0;
			end else begin
				bad = 1'b1;
			end
		endfunction

		function void note_char(in_item_t item);
			res_t exp_res;
			bit   ok;
			if (!bad) begin
				case (phase)
					LINE_IDENT: begin
						phase = LINE_BLANKS;
					end
					LINE_BLANKS: begin
						if (!is_blank(item.ch)) begin
							phase = LINE_FIELDS;
							take_field_char(item.ch);
						end
					end
					default: begin
						take_field_char(item.ch);
					end
				endcase
			end
			if (!item.last)
				return;
			ok = !bad && phase == LINE_FIELDS && field_idx == 2 && digits != 0 &&
				acc <= COMP_MAX && !item.already_entered && !item.map_started;
			exp_res.status = ok;
			exp_res.which  = ok ? item.target : 1'b0;
			exp_res.color  = ok ? {red_green, acc[CompW-1:0]} : '0;
			if (ok) begin
				entered_count++;
				if (item.target == TGT_FLOOR)
					floor_rgb = exp_res.color;
				else
					ceil_rgb = exp_res.color;
			end else begin
				rejected_count++;
			end
			pending_colors.push_back(exp_res);
			clear_line();
		endfunction

		function void check_result(res_t got);
			res_t exp_res;
			if (pending_colors.size() == 0) begin
				$error("unexpected result: status %0d which %0d color %06h",
					got.status, got.which, got.color);
				fails++;
				return;
			end
			exp_res = pending_colors.pop_front();
			if (got.status !== exp_res.status) begin
				$error("status: expected %0d, actual %0d", exp_res.status, got.status);
				fails++;
			end
			if (got.which !== exp_res.which) begin
				$error("which: expected %0d, actual %0d", exp_res.which, got.which);
				fails++;
			end
			if (got.color !== exp_res.color) begin
				$error("color: expected %06h, actual %06h", exp_res.color, got.color);
				fails++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	rgbtp_in_if  chars_if();
	rgbtp_out_if result_if();

	rgb_triplet_text_parser i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	color_line_scoreboard line_sb = new();

	logic [ChW-1:0] line_chars[$];
	int unsigned    chars_sent;
	int unsigned    lines_sent;
	int unsigned    idle_cycles;
	int unsigned    cycle_count;
	bit             calm;
	int             stall_left;

	always #(CLK_HALF) clk = ~clk;

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 15);
		if (r < 10)
			return 0;
		if (r < 14)
			return $urandom_range(1, 3);
		if (r < 15)
			return $urandom_range(4, 8);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [ChW-1:0] pick_blank();
		logic [ChW-1:0] c;
		c = ChW'($urandom_range(CH_TAB - 1, CH_CR));
		if (c < CH_TAB)
			c = CH_SPACE;
		return c;
	endfunction

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_chars.push_back(s[i]);
	endtask

	task automatic send_char(in_item_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid           <= 1'b1;
		chars_if.ch              <= item.ch;
		chars_if.last            <= item.last;
		chars_if.target          <= item.target;
		chars_if.already_entered <= item.already_entered;
		chars_if.map_started     <= item.map_started;
		@(posedge clk);
		while (!chars_if.ready)
			@(posedge clk);
		line_sb.note_char(item);
		chars_sent++;
	endtask

	task automatic send_line(logic tgt, logic ent, logic mp);
		in_item_t item;
		for (int i = 0; i < line_chars.size(); i++) begin
			item.ch   = line_chars[i];
			item.last = (i == line_chars.size() - 1);
			if (item.last) begin
				item.target          = tgt;
				item.already_entered = ent;
				item.map_started     = mp;
			end else begin
				item.target          = 1'($urandom_range(0, 1));
				item.already_entered = 1'($urandom_range(0, 1));
				item.map_started     = 1'($urandom_range(0, 1));
			end
			send_char(item);
		end
		line_chars.delete();
		lines_sent++;
	endtask

	task automatic build_line();
		string field_txt[3];
		int    kind;
		int    r;
		int    pos;
		int    keep;
		line_chars.delete();
		kind = $urandom_range(0, 13);
		if (kind == 13) begin
			repeat ($urandom_range(1, 10))
				line_chars.push_back(ChW'($urandom_range(0, 255)));
			return;
		end
		for (int i = 0; i < 3; i++) begin
			r = $urandom_range(0, 7);
			if (r == 0)
				field_txt[i] = "0";
			else if (r == 1)
				field_txt[i] = "255";
			else
				field_txt[i] = $sformatf("%0d", $urandom_range(0, 255));
		end
		pos = $urandom_range(0, 2);
		case (kind)
			7:  field_txt[pos] = $sformatf("%0d", $urandom_range(256, 9999));
			8:  field_txt[pos] = {"0", $sformatf("%0d", $urandom_range(0, 99))};
			9:  field_txt[pos] = "";
			default: ;
		endcase
		line_chars.push_back(ChW'($urandom_range(0, 255)));
		r = $urandom_range(0, 5);
		if (r > 2)
			r = 0;
		repeat (r)
			line_chars.push_back(pick_blank());
		for (int i = 0; i < 3; i++) begin
			push_text(field_txt[i]);
			if (i < 2)
				line_chars.push_back(CH_COMMA);
		end
		if (kind == 10) begin
			if ($urandom_range(0, 1)) begin
				line_chars.push_back(CH_COMMA);
				push_text($sformatf("%0d", $urandom_range(0, 255)));
			end else begin
				line_chars.push_back(ChW'($urandom_range(0, 255)));
			end
		end else if (kind == 11) begin
			pos = $urandom_range(1, line_chars.size() - 1);
			line_chars[pos] = ChW'($urandom_range(0, 255));
		end else if (kind == 12) begin
			keep = $urandom_range(1, line_chars.size());
			while (line_chars.size() > keep)
				void'(line_chars.pop_back());
		end
	endtask

	initial begin
		result_if.ready = 1'b0;
		stall_left      = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_if.ready <= 1'b0;
				stall_left--;
			end else begin
				result_if.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready)
			line_sb.check_result(res_t'{result_if.status, result_if.which, result_if.color});
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count % 300 == 0)
			calm <= ($urandom_range(0, 3) == 0);
		if ((chars_if.valid && chars_if.ready) || (result_if.valid && result_if.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[rgb_triplet_text_parser] ERROR");
			$finish;
		end
	end

	initial begin
		chars_if.valid           = 1'b0;
		chars_if.ch              = '0;
		chars_if.last            = 1'b0;
		chars_if.target          = TGT_CEILING;
		chars_if.already_entered = 1'b0;
		chars_if.map_started     = 1'b0;
		chars_sent  = 0;
		lines_sent  = 0;
		idle_cycles = 0;
		cycle_count = 0;
		calm        = 1'b0;
		arst_n      = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_text("F 255,255,255");
		send_line(TGT_FLOOR, 1'b0, 1'b0);
		push_text("C0,0,0");
		send_line(TGT_CEILING, 1'b0, 1'b0);
		push_text("C");
		send_line(TGT_CEILING, 1'b0, 1'b0);
		push_text("F");
		line_chars.push_back(8'h00);
		send_line(TGT_FLOOR, 1'b0, 1'b0);
		push_text("C\t");
		send_line(TGT_CEILING, 1'b0, 1'b0);
		push_text("F1,2,3");
		send_line(TGT_FLOOR, 1'b1, 1'b1);

		while (chars_sent < CHAR_COUNT) begin
			build_line();
			send_line(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0,
				$urandom_range(0, 7) == 0);
		end
		chars_if.valid <= 1'b0;

		while (line_sb.pending_colors.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("sent %0d characters in %0d lines: %0d colors entered, %0d lines rejected",
			chars_sent, lines_sent, line_sb.entered_count, line_sb.rejected_count);
		if (line_sb.fails == 0) begin
			$display("[rgb_triplet_text_parser] OK");
		end else begin
			$display("[rgb_triplet_text_parser] ERROR");
		end
		$finish;
	end

endmodule
